>>> rtl/core/apq_pkg.sv
// Shared types, constants and color helpers of the adaptive palette quantizer.
`default_nettype none

package apq_pkg;

    localparam int IDX_W     = 11;
    localparam int WORD_W    = 15;
    localparam int RGB_W     = 12;
    localparam int CH_W      = 4;
    localparam int PEN_OUT_W = 5;
    localparam int CNT_OUT_W = 6;
    localparam int EPOCH_W   = 4;
    localparam int DIST_W    = 10;
    localparam int RED_K_W   = 4;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
    localparam logic [DIST_W-1:0]  DIST_MAX    = '1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap_in;
        logic frame_start;
        logic clear_step;
        logic reduce_step;
        logic hit_take;
        logic alloc;
        logic search_start;
        logic search_step;
        logic search_end;
        logic hit_color;
        logic emit;
    } apq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic epoch_last;
        logic clear_done;
        logic reduce_done;
        logic memo_hit;
        logic pal_full;
        logic search_done;
        logic out_free;
    } apq_status_t;

    // xBGR555 to RGB12 by dropping the low bit of every channel.
    function automatic logic [RGB_W-1:0] to_rgb12(input logic [WORD_W-1:0] w);
        return {w[4:1], w[9:6], w[14:11]};
    endfunction

    // Squared RGB distance of two RGB12 colors; at most 675.
    function automatic logic [DIST_W-1:0] color_dist(input logic [RGB_W-1:0] a,
                                                     input logic [RGB_W-1:0] b);
        logic signed [DIST_W-1:0] dr;
        logic signed [DIST_W-1:0] dg;
        logic signed [DIST_W-1:0] db;
        logic signed [DIST_W-1:0] sum;
        dr  = $signed({{(DIST_W-CH_W){1'b0}}, a[11:8]})
            - $signed({{(DIST_W-CH_W){1'b0}}, b[11:8]});
        dg  = $signed({{(DIST_W-CH_W){1'b0}}, a[7:4]})
            - $signed({{(DIST_W-CH_W){1'b0}}, b[7:4]});
        db  = $signed({{(DIST_W-CH_W){1'b0}}, a[3:0]})
            - $signed({{(DIST_W-CH_W){1'b0}}, b[3:0]});
        sum = dr * dr + dg * dg + db * db;
        return $unsigned(sum);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/apq_ctrl.sv
// Controller state machine of the adaptive palette quantizer.
`default_nettype none

module apq_ctrl
    import apq_pkg::*;
#(
    parameter int INDEX_COUNT = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire apq_status_t status,
    output apq_cmd_t         cmd
);

    localparam bit NEED_MOD = INDEX_COUNT < (1 << IDX_W);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CLEAR   = 4'd1;
    localparam logic [3:0] ST_REDUCE  = 4'd2;
    localparam logic [3:0] ST_LOOKUP  = 4'd3;
    localparam logic [3:0] ST_MEMO    = 4'd4;
    localparam logic [3:0] ST_HITRD   = 4'd5;
    localparam logic [3:0] ST_SEARCH  = 4'd6;
    localparam logic [3:0] ST_SRCHEND = 4'd7;
    localparam logic [3:0] ST_EMIT    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_kind == KIND_FRAME) begin
                        cmd.frame_start = 1'b1;
                        // The epoch tag wraps here, so old memo entries must be wiped.
                        if (status.epoch_last) begin
                            state_next = ST_CLEAR;
                        end
                    end else begin
                        cmd.cap_in = 1'b1;
                        state_next = NEED_MOD ? ST_REDUCE : ST_LOOKUP;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_REDUCE: begin
                cmd.reduce_step = 1'b1;
                if (status.reduce_done) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_MEMO;
            end
            ST_MEMO: begin
                if (status.memo_hit) begin
                    cmd.hit_take = 1'b1;
                    state_next   = ST_HITRD;
                end else if (!status.pal_full) begin
                    cmd.alloc  = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    cmd.search_start = 1'b1;
                    state_next       = ST_SEARCH;
                end
            end
            ST_HITRD: begin
                cmd.hit_color = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_SEARCH: begin
                cmd.search_step = 1'b1;
                if (status.search_done) begin
                    state_next = ST_SRCHEND;
                end
            end
            ST_SRCHEND: begin
                cmd.search_end = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/apq_datapath.sv
// Datapath of the adaptive palette quantizer: memo, palette, search and output register.
`default_nettype none

module apq_datapath
    import apq_pkg::*;
#(
    parameter int INDEX_COUNT  = 2048,
    parameter int PALETTE_SIZE = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire apq_cmd_t             cmd,
    output apq_status_t               status,
    input  wire logic [IDX_W-1:0]     s_color_index,
    input  wire logic [WORD_W-1:0]    s_color_word,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [PEN_OUT_W-1:0]      m_pen,
    output logic                      m_new_entry,
    output logic [RGB_W-1:0]          m_entry_color,
    output logic [CNT_OUT_W-1:0]      m_used_count
);

    localparam int MEMO_DEPTH = (INDEX_COUNT < (1 << IDX_W)) ? INDEX_COUNT : (1 << IDX_W);
    localparam int MA_W       = $clog2(MEMO_DEPTH);
    localparam int PEN_W      = $clog2(PALETTE_SIZE);
    localparam int CNT_W      = $clog2(PALETTE_SIZE + 1);
    localparam int MEMO_W     = EPOCH_W + PEN_W;
    localparam int MOD_W      = 2 * IDX_W;
    localparam int PROD_W     = IDX_W + MOD_W;

    // Reciprocal of the index count, scaled by 2**MOD_W and rounded down.
    localparam logic [MOD_W-1:0] RECIP = MOD_W'((64'd1 << MOD_W) / INDEX_COUNT);

    // Pixel being worked on.
    logic [IDX_W-1:0]   idx_reg;
    logic [RGB_W-1:0]   color_reg;
    logic [RED_K_W-1:0] red_k_reg;
    logic [IDX_W-1:0]   quo_reg;
    logic [PEN_W-1:0]   pen_reg;
    logic               fresh_reg;

    // Frame state.
    logic [CNT_W-1:0]   used_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [MA_W-1:0]    clr_cnt_reg;

    // Search state.
    logic [CNT_W-1:0]   sc_reg;
    logic               rdv_reg;
    logic [PEN_W-1:0]   sidx_reg;
    logic [PEN_W-1:0]   best_reg;
    logic [DIST_W-1:0]  best_d_reg;
    logic [RGB_W-1:0]   best_color_reg;

    // Output register.
    logic                 m_valid_reg;
    logic [PEN_OUT_W-1:0] m_pen_reg;
    logic                 m_new_entry_reg;
    logic [RGB_W-1:0]     m_color_reg;
    logic [CNT_OUT_W-1:0] m_used_reg;

    // Memories.
    logic [MEMO_W-1:0] memo_mem [MEMO_DEPTH];
    logic [MEMO_W-1:0] memo_rdata_reg;
    logic [RGB_W-1:0]  pal_mem [PALETTE_SIZE];
    logic [RGB_W-1:0]  pal_rdata_reg;

    logic [PROD_W-1:0]  recip_prod;
    logic [MOD_W-1:0]   quo_mul;
    logic [MOD_W-1:0]   rem_ext;
    logic [MOD_W-1:0]   modulus;
    logic               rem_ge;
    logic [MA_W-1:0]    memo_addr;
    logic               memo_we;
    logic [MA_W-1:0]    memo_waddr;
    logic [MEMO_W-1:0]  memo_wdata;
    logic [EPOCH_W-1:0] memo_tag;
    logic [PEN_W-1:0]   memo_pen;
    logic [PEN_W-1:0]   used_pen;
    logic [PEN_W-1:0]   pal_raddr;
    logic [DIST_W-1:0]  cand_dist;
    logic               sc_more;
    logic               out_free;

    assign modulus    = MOD_W'(INDEX_COUNT);
    assign recip_prod = PROD_W'(idx_reg) * PROD_W'(RECIP);
    assign quo_mul    = MOD_W'(quo_reg) * modulus;
    assign rem_ext    = MOD_W'(idx_reg) - quo_mul;
    assign rem_ge     = rem_ext >= modulus;
    assign memo_addr  = idx_reg[MA_W-1:0];
    assign memo_tag   = memo_rdata_reg[MEMO_W-1 -: EPOCH_W];
    assign memo_pen   = memo_rdata_reg[PEN_W-1:0];
    assign used_pen   = used_reg[PEN_W-1:0];
    assign cand_dist  = color_dist(pal_rdata_reg, color_reg);
    assign sc_more    = sc_reg < CNT_W'(PALETTE_SIZE);
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        memo_we    = cmd.clear_step | cmd.alloc | cmd.search_end;
        memo_waddr = memo_addr;
        memo_wdata = {epoch_reg, best_reg};
        if (cmd.clear_step) begin
            memo_waddr = clr_cnt_reg;
            memo_wdata = '0;
        end else if (cmd.alloc) begin
            memo_wdata = {epoch_reg, used_pen};
        end
        pal_raddr = cmd.search_step ? sc_reg[PEN_W-1:0] : memo_pen;
    end

    always_ff @(posedge aclk) begin
        if (memo_we) begin
            memo_mem[memo_waddr] <= memo_wdata;
        end
        memo_rdata_reg <= memo_mem[memo_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.alloc) begin
            pal_mem[used_pen] <= color_reg;
        end
        pal_rdata_reg <= pal_mem[pal_raddr];
    end

    // Frame-level control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            epoch_reg   <= EPOCH_FIRST;
            clr_cnt_reg <= '0;
        end else begin
            if (cmd.frame_start) begin
                used_reg    <= '0;
                epoch_reg   <= (epoch_reg == EPOCH_LAST) ? EPOCH_FIRST : epoch_reg + 1'b1;
                clr_cnt_reg <= '0;
            end else begin
                if (cmd.alloc) begin
                    used_reg <= used_reg + 1'b1;
                end
                if (cmd.clear_step) begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
            end
        end
    end

    // Per-pixel work registers.
    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            idx_reg   <= s_color_index;
            color_reg <= to_rgb12(s_color_word);
            red_k_reg <= RED_K_W'(1);
        end
        // The index remainder takes two steps: a reciprocal estimate of the quotient,
        // which is at most one low, then one corrective subtraction.
        if (cmd.reduce_step) begin
            if (red_k_reg != '0) begin
                quo_reg <= recip_prod[PROD_W-1 -: IDX_W];
            end else begin
                idx_reg <= IDX_W'(rem_ge ? rem_ext - modulus : rem_ext);
            end
            red_k_reg <= red_k_reg - 1'b1;
        end
        if (cmd.hit_take) begin
            pen_reg   <= memo_pen;
            fresh_reg <= 1'b0;
        end
        if (cmd.alloc) begin
            pen_reg   <= used_pen;
            fresh_reg <= 1'b1;
        end
        if (cmd.hit_color) begin
            color_reg <= pal_rdata_reg;
        end
        if (cmd.search_end) begin
            pen_reg   <= best_reg;
            fresh_reg <= 1'b0;
            color_reg <= best_color_reg;
        end
    end

    // Nearest-entry search: one palette read per cycle, each compared in the cycle after its read.
    always_ff @(posedge aclk) begin
        if (cmd.search_start) begin
            sc_reg     <= '0;
            rdv_reg    <= 1'b0;
            best_reg   <= '0;
            best_d_reg <= DIST_MAX;
        end else if (cmd.search_step) begin
            if (sc_more) begin
                sc_reg <= sc_reg + 1'b1;
            end
            rdv_reg  <= sc_more;
            sidx_reg <= sc_reg[PEN_W-1:0];
            // Strict compare keeps the lowest entry on a tie.
            if (rdv_reg && (cand_dist < best_d_reg)) begin
                best_d_reg     <= cand_dist;
                best_reg       <= sidx_reg;
                best_color_reg <= pal_rdata_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_pen_reg       <= PEN_OUT_W'(pen_reg);
            m_new_entry_reg <= fresh_reg;
            m_color_reg     <= color_reg;
            m_used_reg      <= CNT_OUT_W'(used_reg);
        end
    end

    assign status.epoch_last  = epoch_reg == EPOCH_LAST;
    assign status.clear_done  = clr_cnt_reg == MA_W'(MEMO_DEPTH - 1);
    assign status.reduce_done = red_k_reg == '0;
    assign status.memo_hit    = memo_tag == epoch_reg;
    assign status.pal_full    = used_reg == CNT_W'(PALETTE_SIZE);
    assign status.search_done = !sc_more;
    assign status.out_free    = out_free;

    assign m_valid       = m_valid_reg;
    assign m_pen         = m_pen_reg;
    assign m_new_entry   = m_new_entry_reg;
    assign m_entry_color = m_color_reg;
    assign m_used_count  = m_used_reg;

endmodule

`default_nettype wire

>>> rtl/core/adaptive_palette_quantizer_core.sv
// Adaptive palette quantizer, one word at a time. A memo hit takes its pen from the memo and
// its color from the palette; a miss with a free entry allocates one; a miss on a full palette
// runs the one-read-per-cycle palette scan. INDEX_COUNT below 2048 adds an index reduction.
// Every 15th frame start also runs a memo clearing pass over min(INDEX_COUNT, 2048) entries
// through the memo write port.
// After reset (synchronous, active low) the same clearing pass runs before s_ready rises.
`default_nettype none

module adaptive_palette_quantizer_core
    import apq_pkg::*;
#(
    parameter int INDEX_COUNT  = 2048,
    parameter int PALETTE_SIZE = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_kind,
    input  wire logic [IDX_W-1:0]     s_color_index,
    input  wire logic [WORD_W-1:0]    s_color_word,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [PEN_OUT_W-1:0]      m_pen,
    output logic                      m_new_entry,
    output logic [RGB_W-1:0]          m_entry_color,
    output logic [CNT_OUT_W-1:0]      m_used_count
);

    apq_cmd_t    cmd;
    apq_status_t status;

    apq_ctrl #(
        .INDEX_COUNT (INDEX_COUNT)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .status  (status),
        .cmd     (cmd)
    );

    apq_datapath #(
        .INDEX_COUNT  (INDEX_COUNT),
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_color_index (s_color_index),
        .s_color_word  (s_color_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pen         (m_pen),
        .m_new_entry   (m_new_entry),
        .m_entry_color (m_entry_color),
        .m_used_count  (m_used_count)
    );

endmodule

`default_nettype wire

>>> verif/tb_adaptive_palette_quantizer_core.sv
// Self-checking testbench of the adaptive palette quantizer core with its own pen predictor.
`timescale 1ns / 1ps

module tb_adaptive_palette_quantizer_core
    import apq_pkg::*;
();

    localparam int MEMO_DEPTH   = 2048;
    localparam int PAL_ENTRIES  = 32;
    localparam int RANDOM_WORDS = 1600;
    localparam int PHASE_WORDS  = 150;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 600000;

    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SRC_IDLE,
        PH_SINK_STALL,
        PH_BOTH
    } traffic_phase_e;

    typedef struct {
        logic               kind;
        logic [IDX_W-1:0]   idx;
        logic [WORD_W-1:0]  word;
        bit                 hold;
    } quant_req_t;

    typedef struct {
        logic [PEN_OUT_W-1:0] pen;
        logic                 new_entry;
        logic [RGB_W-1:0]     color;
        logic [CNT_OUT_W-1:0] used;
    } pen_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_kind = KIND_FRAME;
    logic [IDX_W-1:0]     s_color_index = '0;
    logic [WORD_W-1:0]    s_color_word = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PEN_OUT_W-1:0] m_pen;
    logic                 m_new_entry;
    logic [RGB_W-1:0]     m_entry_color;
    logic [CNT_OUT_W-1:0] m_used_count;

    quant_req_t     req_queue[$];
    pen_result_t    pen_expect_q[$];
    quant_req_t     active_req;
    traffic_phase_e traffic_phase = PH_STEADY;
    int unsigned    words_accepted = 0;
    int unsigned    mismatches = 0;
    int unsigned    cycle_count = 0;

    // Predictor state: memo per source index, output palette and allocation count.
    bit                   memo_valid [0:MEMO_DEPTH-1];
    logic [PEN_OUT_W-1:0] memo_pen [0:MEMO_DEPTH-1];
    logic [RGB_W-1:0]     pal_rgb [0:PAL_ENTRIES-1];
    int unsigned          entries_taken = 0;

    logic [WORD_W-1:0]    frame_color [0:MEMO_DEPTH-1];
    logic [4:0]           coarse_level [0:3] = '{5'h00, 5'h0f, 5'h10, 5'h1f};

    adaptive_palette_quantizer_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_color_index (s_color_index),
        .s_color_word  (s_color_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pen         (m_pen),
        .m_new_entry   (m_new_entry),
        .m_entry_color (m_entry_color),
        .m_used_count  (m_used_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic quantize_word(input quant_req_t req);
        int               i;
        int               best_d;
        int               d;
        int               dr;
        int               dg;
        int               db;
        int unsigned      pen;
        logic [RGB_W-1:0] rgb;
        pen_result_t      res;
        if (req.kind == KIND_FRAME) begin
            for (i = 0; i < MEMO_DEPTH; i++) memo_valid[i] = 1'b0;
            entries_taken = 0;
            return;
        end
        res.new_entry = 1'b0;
        if (memo_valid[req.idx]) begin
            pen = memo_pen[req.idx];
        end else begin
            rgb[11:8] = 4'(req.word[4:0] >> 1);
            rgb[7:4]  = 4'(req.word[9:5] >> 1);
            rgb[3:0]  = 4'(req.word[14:10] >> 1);
            if (entries_taken < PAL_ENTRIES) begin
                pen = entries_taken;
                entries_taken++;
                pal_rgb[pen] = rgb;
                res.new_entry = 1'b1;
            end else begin
                // Strict less-than keeps the lowest entry on equal distances.
                pen = 0;
                best_d = 1 << 20;
                for (i = 0; i < PAL_ENTRIES; i++) begin
                    dr = int'(pal_rgb[i][11:8]) - int'(rgb[11:8]);
                    dg = int'(pal_rgb[i][7:4]) - int'(rgb[7:4]);
                    db = int'(pal_rgb[i][3:0]) - int'(rgb[3:0]);
                    d = dr * dr + dg * dg + db * db;
                    if (d < best_d) begin
                        best_d = d;
                        pen = i;
                    end
                end
            end
            memo_valid[req.idx] = 1'b1;
            memo_pen[req.idx] = PEN_OUT_W'(pen);
        end
        res.pen   = PEN_OUT_W'(pen);
        res.color = pal_rgb[pen];
        res.used  = CNT_OUT_W'(entries_taken);
        pen_expect_q.push_back(res);
    endtask

    function automatic void push_req(input logic kind, input logic [IDX_W-1:0] idx,
                                     input logic [WORD_W-1:0] word, input bit hold);
        quant_req_t req;
        req.kind = kind;
        req.idx  = idx;
        req.word = word;
        req.hold = hold;
        req_queue.push_back(req);
    endfunction

    function automatic bit gap_now(input traffic_phase_e own_phase);
        if (traffic_phase == own_phase) return $urandom_range(0, 99) < 62;
        if (traffic_phase == PH_BOTH) return $urandom_range(0, 99) < 17;
        return 1'b0;
    endfunction

    // Driver: a word stays on the bus until it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                quantize_word(active_req);
                words_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (req_queue.size() != 0 && !gap_now(PH_SRC_IDLE) &&
                    !(req_queue[0].hold && pen_expect_q.size() != 0)) begin
                    active_req = req_queue.pop_front();
                    s_valid       <= 1'b1;
                    s_kind        <= active_req.kind;
                    s_color_index <= active_req.idx;
                    s_color_word  <= active_req.word;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            traffic_phase <= traffic_phase_e'((words_accepted / PHASE_WORDS) % 4);
        end
    end

    // Monitor: every result word is checked against the oldest prediction.
    always @(posedge aclk) begin
        pen_result_t exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pen_expect_q.size() == 0) begin
                    $display("%0t: unexpected result word pen %0d new %0d color %03h used %0d",
                             $time, m_pen, m_new_entry, m_entry_color, m_used_count);
                    mismatches++;
                end else begin
                    exp_res = pen_expect_q.pop_front();
                    if (m_pen !== exp_res.pen || m_new_entry !== exp_res.new_entry ||
                        m_entry_color !== exp_res.color || m_used_count !== exp_res.used) begin
                        $display("%0t: expected pen %0d new %0d color %03h used %0d", $time,
                                 exp_res.pen, exp_res.new_entry, exp_res.color, exp_res.used);
                        $display("%0t: actual   pen %0d new %0d color %03h used %0d", $time,
                                 m_pen, m_new_entry, m_entry_color, m_used_count);
                        mismatches++;
                    end
                end
            end
            m_ready <= !gap_now(PH_SINK_STALL);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[adaptive_palette_quantizer_core] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned       generated;
        int unsigned       total_words;
        int unsigned       pool;
        int unsigned       base;
        int unsigned       style;
        int unsigned       frame_len;
        int unsigned       k;
        int unsigned       roll;
        logic [4:0]        gray;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] col;

        // Directed: field extremes, memo hits with a stale color, repeated frame starts.
        push_req(KIND_FRAME, 11'h7ff, 15'h7fff, 1'b0);
        push_req(KIND_PIXEL, 11'h000, 15'h0000, 1'b0);
        push_req(KIND_PIXEL, 11'h7ff, 15'h7fff, 1'b0);
        push_req(KIND_PIXEL, 11'h000, 15'h7fff, 1'b0);
        push_req(KIND_PIXEL, 11'h7ff, 15'h0000, 1'b0);
        push_req(KIND_PIXEL, 11'h2aa, 15'h5555, 1'b0);
        push_req(KIND_PIXEL, 11'h555, 15'h2aaa, 1'b0);
        push_req(KIND_PIXEL, 11'h003, 15'h0421, 1'b0);
        push_req(KIND_FRAME, 11'h000, 15'h0000, 1'b0);
        push_req(KIND_FRAME, 11'h2aa, 15'h5555, 1'b0);
        push_req(KIND_PIXEL, 11'h000, 15'h001f, 1'b1);
        push_req(KIND_PIXEL, 11'h000, 15'h7c00, 1'b0);
        push_req(KIND_PIXEL, 11'h7ff, 15'h03e0, 1'b0);

        // Random frames: a consistent color per index, with some noise and cut frames.
        generated = 0;
        while (generated < RANDOM_WORDS) begin
            push_req(KIND_FRAME, IDX_W'($urandom), WORD_W'($urandom),
                     $urandom_range(0, 19) == 0);
            generated++;
            pool  = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 24) : $urandom_range(33, 120);
            base  = $urandom_range(0, MEMO_DEPTH - 1);
            style = $urandom_range(0, 2);
            for (k = 0; k < pool; k++) begin
                case (style)
                    0: begin
                        col = WORD_W'($urandom);
                    end
                    1: begin
                        col = {coarse_level[$urandom_range(0, 3)],
                               coarse_level[$urandom_range(0, 3)],
                               coarse_level[$urandom_range(0, 3)]};
                    end
                    default: begin
                        gray = 5'($urandom);
                        col = {gray, gray, gray};
                    end
                endcase
                frame_color[(base + k) % MEMO_DEPTH] = col;
            end
            frame_len = $urandom_range(20, 90);
            for (k = 0; k < frame_len; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    push_req(KIND_FRAME, IDX_W'($urandom), WORD_W'($urandom), 1'b0);
                end else if (roll < 10) begin
                    push_req(KIND_PIXEL, IDX_W'($urandom), WORD_W'($urandom),
                             $urandom_range(0, 199) == 0);
                end else begin
                    idx = IDX_W'((base + $urandom_range(0, pool - 1)) % MEMO_DEPTH);
                    col = ($urandom_range(0, 9) == 0) ? WORD_W'($urandom) : frame_color[idx];
                    push_req(KIND_PIXEL, idx, col, $urandom_range(0, 199) == 0);
                end
                generated++;
            end
        end
        total_words = req_queue.size();

        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Every word must be taken before the remaining results are awaited.
        while (words_accepted != total_words) @(posedge aclk);
        while (pen_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pen_expect_q.size() == 0) begin
            $display("[adaptive_palette_quantizer_core] OK");
        end else begin
            $display("[adaptive_palette_quantizer_core] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/apq_pkg.sv
rtl/core/apq_ctrl.sv
rtl/core/apq_datapath.sv
rtl/core/adaptive_palette_quantizer_core.sv
verif/tb_adaptive_palette_quantizer_core.sv
